/* hdl/mds_pkg.sv */
// ----------------------------------------------------------------------------
// mds_pkg - shared types and constants for the stereo downmix core
// Item structs, sample format codes, register indexes and the gain constants.
// ----------------------------------------------------------------------------
`default_nettype none

package mds_pkg;

  localparam int unsigned NUM_CH     = 8;
  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned X_W        = 32;
  localparam int unsigned PROD_W     = 49;
  localparam int unsigned SCALED_W   = 33;
  localparam int unsigned SUM_W      = 34;
  localparam int unsigned FS_PROD_W  = 50;
  localparam int unsigned OUT_W      = 16;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 4;

  localparam logic [16:0] GAIN_Q16   = 17'd45875;
  localparam logic [15:0] FULL_SCALE = 16'd32767;

  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT = 1'b1;

  localparam logic [CNT_W-1:0] CH_COUNT_RESET = 4'd6;

  typedef enum logic [2:0] {
    FMT_S16 = 3'd0,
    FMT_S24 = 3'd1,
    FMT_S32 = 3'd2,
    FMT_F32 = 3'd3
  } fmt_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] ch0_sample;
    logic [SAMPLE_W-1:0] ch1_sample;
    logic [SAMPLE_W-1:0] ch2_sample;
    logic [SAMPLE_W-1:0] ch3_sample;
    logic [SAMPLE_W-1:0] ch4_sample;
    logic [SAMPLE_W-1:0] ch5_sample;
    logic [SAMPLE_W-1:0] ch6_sample;
    logic [SAMPLE_W-1:0] ch7_sample;
    logic                frame_last;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] left_out;
    logic signed [OUT_W-1:0] right_out;
    logic                    last_out;
  } out_item_t;

  function automatic logic signed [X_W-1:0] to_sample(input logic [SAMPLE_W-1:0] raw,
                                                       input fmt_t fmt);
    logic signed [X_W-1:0] x;
    case (fmt)
      FMT_S16: x = {{16{raw[15]}}, raw[15:0]};
      FMT_S24: x = {{16{raw[23]}}, raw[23:8]};
      default: x = raw;
    endcase
    return x;
  endfunction

endpackage

`default_nettype wire

/* hdl/multichannel_downmix_stereo_core.sv */
// ----------------------------------------------------------------------------
// multichannel_downmix_stereo_core - surround frame to stereo pair downmix
// Five gain lanes scale center, side and back channels, a merge stage sums
// them with the front pair, and per-side scalers saturate to 16 bits.
//
//   channel  ports                           direction  handshake
//   input    in_data, start, busy            in         start & !busy
//   result   out_data, out_valid             out        strobe, no stall
//   config   cfg_we, cfg_index, cfg_wdata    in         write on cfg_we
//
// One item per cycle while busy is low; out_valid rises once the item has passed
// four register stages: lane multiply, merge sum, full-scale multiply, saturate.
// busy is high during reset, falls at the first clock edge after reset is released and stays low.
// Results cannot be held off and leave on a one-cycle strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_downmix_stereo_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  mds_pkg::in_item_t                      in_data,
  output logic                                   out_valid,
  output mds_pkg::out_item_t                     out_data,
  input  wire logic                              cfg_we,
  input  wire logic [mds_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mds_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import mds_pkg::*;

  localparam int unsigned LAT = 4;

  logic [CNT_W-1:0]        channel_count_r;
  fmt_t                    sample_format_r;
  logic                    busy_r;
  logic [LAT-1:0]          valid_r, valid_nxt;
  logic [LAT-1:0]          last_r, last_nxt;
  logic                    accept;
  logic signed [X_W-1:0]   front_l_r, front_r_r;
  logic signed [SCALED_W-1:0] c_s, sl_s, sr_s, bl_s, br_s;
  logic signed [SUM_W-1:0] sum_l, sum_r;
  logic signed [OUT_W-1:0] res_l, res_r;

  assign accept = start & ~busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_count_r <= CH_COUNT_RESET;
      sample_format_r <= FMT_F32;
      busy_r          <= 1'b1;
      valid_r         <= '0;
    end else begin
      busy_r  <= 1'b0;
      valid_r <= valid_nxt;
      if (cfg_we && cfg_index == REG_CHANNEL_COUNT) begin
        channel_count_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == REG_SAMPLE_FORMAT) begin
        sample_format_r <= fmt_t'(cfg_wdata[2:0]);
      end
    end
  end

  always_comb begin
    valid_nxt = {valid_r[LAT-2:0], accept};
    last_nxt  = {last_r[LAT-2:0], in_data.frame_last};
  end

  always_ff @(posedge clk) begin
    last_r    <= last_nxt;
    front_l_r <= to_sample(in_data.ch0_sample, sample_format_r);
    front_r_r <= to_sample(in_data.ch1_sample, sample_format_r);
  end

  mds_lane u_lane_c (
    .clk(clk), .raw(in_data.ch2_sample), .fmt(sample_format_r),
    .use_ch(1'b1), .scaled(c_s)
  );
  mds_lane u_lane_sl (
    .clk(clk), .raw(in_data.ch4_sample), .fmt(sample_format_r),
    .use_ch(channel_count_r >= CNT_W'(5)), .scaled(sl_s)
  );
  mds_lane u_lane_sr (
    .clk(clk), .raw(in_data.ch5_sample), .fmt(sample_format_r),
    .use_ch(channel_count_r >= CNT_W'(6)), .scaled(sr_s)
  );
  mds_lane u_lane_bl (
    .clk(clk), .raw(in_data.ch6_sample), .fmt(sample_format_r),
    .use_ch(channel_count_r >= CNT_W'(7)), .scaled(bl_s)
  );
  mds_lane u_lane_br (
    .clk(clk), .raw(in_data.ch7_sample), .fmt(sample_format_r),
    .use_ch(channel_count_r >= CNT_W'(8)), .scaled(br_s)
  );

  mds_mix u_mix (
    .clk(clk), .front_l(front_l_r), .front_r(front_r_r), .center(c_s),
    .side_l(sl_s), .side_r(sr_s), .back_l(bl_s), .back_r(br_s),
    .sum_l(sum_l), .sum_r(sum_r)
  );

  mds_scale u_scale_l (
    .clk(clk), .fmt(sample_format_r), .sum(sum_l), .result(res_l)
  );
  mds_scale u_scale_r (
    .clk(clk), .fmt(sample_format_r), .sum(sum_r), .result(res_r)
  );

  always_comb begin
    busy               = busy_r;
    out_valid          = valid_r[LAT-1];
    out_data.left_out  = res_l;
    out_data.right_out = res_r;
    out_data.last_out  = last_r[LAT-1];
  end

endmodule

`default_nettype wire

/* hdl/mds_lane.sv */
// ----------------------------------------------------------------------------
// mds_lane - one gain lane of the downmix
// Formats a raw sample, multiplies by the Q16 gain and truncates toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module mds_lane (
  input  wire logic                                  clk,
  input  wire logic [mds_pkg::SAMPLE_W-1:0]          raw,
  input  mds_pkg::fmt_t                              fmt,
  input  wire logic                                  use_ch,
  output logic signed [mds_pkg::SCALED_W-1:0]        scaled
);
  import mds_pkg::*;

  logic signed [X_W-1:0]    x;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] biased;

  always_comb begin
    x        = use_ch ? to_sample(raw, fmt) : '0;
    prod_nxt = PROD_W'(x * $signed(GAIN_Q16));
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  always_comb begin
    biased = prod_r + (prod_r[PROD_W-1] ? PROD_W'(65535) : '0);
    scaled = biased[PROD_W-1:16];
  end

endmodule

`default_nettype wire

/* hdl/mds_mix.sv */
// ----------------------------------------------------------------------------
// mds_mix - merge stage of the downmix
// Adds the front samples and the scaled lanes into left and right sums.
// ----------------------------------------------------------------------------
`default_nettype none

module mds_mix (
  input  wire logic                                clk,
  input  wire logic signed [mds_pkg::X_W-1:0]      front_l,
  input  wire logic signed [mds_pkg::X_W-1:0]      front_r,
  input  wire logic signed [mds_pkg::SCALED_W-1:0] center,
  input  wire logic signed [mds_pkg::SCALED_W-1:0] side_l,
  input  wire logic signed [mds_pkg::SCALED_W-1:0] side_r,
  input  wire logic signed [mds_pkg::SCALED_W-1:0] back_l,
  input  wire logic signed [mds_pkg::SCALED_W-1:0] back_r,
  output logic signed [mds_pkg::SUM_W-1:0]         sum_l,
  output logic signed [mds_pkg::SUM_W-1:0]         sum_r
);
  import mds_pkg::*;

  logic signed [SUM_W-1:0] sum_l_r, sum_l_nxt;
  logic signed [SUM_W-1:0] sum_r_r, sum_r_nxt;

  always_comb begin
    sum_l_nxt = SUM_W'(front_l) + SUM_W'(center) + SUM_W'(side_l) + SUM_W'(back_l);
    sum_r_nxt = SUM_W'(front_r) + SUM_W'(center) + SUM_W'(side_r) + SUM_W'(back_r);
  end

  always_ff @(posedge clk) begin
    sum_l_r <= sum_l_nxt;
    sum_r_r <= sum_r_nxt;
  end

  assign sum_l = sum_l_r;
  assign sum_r = sum_r_r;

endmodule

`default_nettype wire

/* hdl/mds_scale.sv */
// ----------------------------------------------------------------------------
// mds_scale - output scaling for one side
// Brings a mixed sum to 16 bits per sample format and saturates it; unsupported formats give zero.
// ----------------------------------------------------------------------------
`default_nettype none

module mds_scale (
  input  wire logic                                clk,
  input  mds_pkg::fmt_t                            fmt,
  input  wire logic signed [mds_pkg::SUM_W-1:0]    sum,
  output logic signed [mds_pkg::OUT_W-1:0]         result
);
  import mds_pkg::*;

  logic signed [FS_PROD_W-1:0] prod_r, prod_nxt;
  logic signed [SUM_W-1:0]     sum_d_r;
  logic signed [FS_PROD_W-1:0] biased;
  logic signed [FS_PROD_W-1:0] v;
  logic                        silent;
  logic signed [OUT_W-1:0]     result_r, result_nxt;

  always_comb begin
    prod_nxt = FS_PROD_W'(sum * $signed({1'b0, FULL_SCALE}));
  end

  always_ff @(posedge clk) begin
    prod_r   <= prod_nxt;
    sum_d_r  <= sum;
    result_r <= result_nxt;
  end

  always_comb begin
    biased = prod_r + (prod_r[FS_PROD_W-1] ? FS_PROD_W'(24'hFFFFFF) : '0);
    silent = 1'b0;
    case (fmt)
      FMT_S16, FMT_S24: v = FS_PROD_W'(sum_d_r);
      FMT_S32:          v = FS_PROD_W'(sum_d_r >>> 16);
      FMT_F32:          v = biased >>> 24;
      default: begin
        v      = '0;
        silent = 1'b1;
      end
    endcase
    if (silent) begin
      result_nxt = '0;
    end else if (v > FS_PROD_W'(32767)) begin
      result_nxt = 16'sh7FFF;
    end else if (v < -FS_PROD_W'(32768)) begin
      result_nxt = 16'sh8000;
    end else begin
      result_nxt = v[OUT_W-1:0];
    end
  end

  assign result = result_r;

endmodule

`default_nettype wire

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb - testbench for multichannel_downmix_stereo_core
// Feeds surround frames over the start/busy command port, predicts each
// stereo pair from its own copy of channel count and sample format, and
// compares every strobed result against the oldest prediction. Runs a short
// directed set per format, then random phases over register settings
// (extremes, out-of-range counts, unsupported formats) with sender idling.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mds_pkg::*;

  localparam int          LATENCY      = 4;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          PHASE_ITEMS  = 97;
  localparam int          NUM_PHASES   = 16;
  localparam longint      MIX_GAIN     = 45875;
  localparam longint      OUT_FULL     = 32767;
  localparam logic [2:0]  FMT_NONE     = 3'd4;

  logic       clk;
  logic       rst_n     = 1'b0;
  logic       start     = 1'b0;
  logic       busy;
  in_item_t   in_data   = '0;
  logic       out_valid;
  out_item_t  out_data;
  logic       cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  in_item_t   pending_frames [$];
  out_item_t  expected_pairs [$];
  logic [3:0] mix_channels = CH_COUNT_RESET;
  logic [2:0] mix_format   = FMT_F32;
  int         send_idle    = 0;
  int         mismatches   = 0;
  int         cycle_count  = 0;

  multichannel_downmix_stereo_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  function automatic longint trunc_shift(longint p, int sh);
    return (p < 0) ? -((-p) >>> sh) : (p >>> sh);
  endfunction

  function automatic longint gain(longint x);
    return trunc_shift(x * MIX_GAIN, 16);
  endfunction

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic out_item_t downmix_pair(in_item_t fr, logic [3:0] cnt, logic [2:0] fmt);
    logic [31:0] raw [8];
    longint      x [8];
    longint      lsum;
    longint      rsum;
    longint      ctr;
    int          n;
    out_item_t   r;
    raw = '{fr.ch0_sample, fr.ch1_sample, fr.ch2_sample, fr.ch3_sample,
            fr.ch4_sample, fr.ch5_sample, fr.ch6_sample, fr.ch7_sample};
    n = (cnt < 3) ? 3 : (cnt > 8) ? 8 : int'(cnt);
    lsum = 0;
    rsum = 0;
    if (fmt <= FMT_F32) begin
      for (int i = 0; i < 8; i++) begin
        case (fmt)
          FMT_S16: x[i] = longint'($signed(raw[i][15:0]));
          FMT_S24: x[i] = longint'($signed(raw[i][23:0])) >>> 8;
          default: x[i] = longint'($signed(raw[i]));
        endcase
      end
      ctr  = gain(x[2]);
      lsum = x[0] + ctr;
      rsum = x[1] + ctr;
      if (n >= 5) lsum += gain(x[4]);
      if (n >= 6) rsum += gain(x[5]);
      if (n >= 7) lsum += gain(x[6]);
      if (n >= 8) rsum += gain(x[7]);
      if (fmt == FMT_S32) begin
        lsum = lsum >>> 16;
        rsum = rsum >>> 16;
      end else if (fmt == FMT_F32) begin
        lsum = trunc_shift(lsum * OUT_FULL, 24);
        rsum = trunc_shift(rsum * OUT_FULL, 24);
      end
      lsum = clip16(lsum);
      rsum = clip16(rsum);
    end
    r.left_out  = lsum[15:0];
    r.right_out = rsum[15:0];
    r.last_out  = fr.frame_last;
    return r;
  endfunction

  function automatic in_item_t random_frame(logic [2:0] fmt);
    logic [255:0] s;
    logic [31:0]  v;
    logic [31:0]  keep;
    int unsigned  span;
    int unsigned  mode;
    bit           all_small;
    case (fmt)
      FMT_S16: begin span = 1 << 12; keep = 32'h0000_FFFF; end
      FMT_S24: begin span = 1 << 20; keep = 32'h00FF_FFFF; end
      FMT_S32: begin span = 1 << 28; keep = 32'hFFFF_FFFF; end
      FMT_F32: begin span = 1 << 22; keep = 32'hFFFF_FFFF; end
      default: begin span = 1 << 12; keep = 32'h0000_FFFF; end
    endcase
    all_small = 1'($urandom_range(1));
    for (int i = 0; i < 8; i++) begin
      mode = all_small ? 1 : $urandom_range(3);
      case (mode)
        1: begin
          v = $urandom_range(2 * span - 1) - span;
          v = (v & keep) | ($urandom & ~keep);
        end
        2: begin
          case ($urandom_range(3))
            0:       v = 32'h7FFF_FFFF;
            1:       v = 32'h8000_0000;
            2:       v = 32'h0000_0000;
            default: v = 32'hFFFF_FFFF;
          endcase
        end
        default: v = $urandom;
      endcase
      s[i*32 +: 32] = v;
    end
    return {s, 1'($urandom_range(1))};
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [3:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_CHANNEL_COUNT) mix_channels = val;
    else mix_format = val[2:0];
  endtask

  task automatic drain();
    while (pending_frames.size() != 0 || expected_pairs.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic load_directed();
    logic [31:0] uni [4];
    in_item_t    fr;
    uni = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
    for (int k = 0; k < 4; k++) begin
      fr = {{8{uni[k]}}, 1'(k % 2)};
      pending_frames.push_back(fr);
    end
    fr.ch0_sample = 32'h0000_7FFF;
    fr.ch1_sample = 32'hFFFF_8000;
    fr.ch2_sample = 32'h0080_0000;
    fr.ch3_sample = 32'hAAAA_AAAA;
    fr.ch4_sample = 32'h5555_5555;
    fr.ch5_sample = 32'h00FF_00FF;
    fr.ch6_sample = 32'h1234_5678;
    fr.ch7_sample = 32'hFEDC_BA98;
    fr.frame_last = 1'b1;
    pending_frames.push_back(fr);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_pairs.push_back(downmix_pair(in_data, mix_channels, mix_format));
        void'(pending_frames.pop_front());
      end
      if (!(start && busy)) begin
        if (pending_frames.size() != 0 && $urandom_range(99) >= send_idle) begin
          start   <= 1'b1;
          in_data <= pending_frames[0];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst_n && out_valid) begin
      if (expected_pairs.size() == 0) begin
        $display("%0t: unexpected item left %0d right %0d last %0b", $time,
                 out_data.left_out, out_data.right_out, out_data.last_out);
        mismatches++;
      end else begin
        want = expected_pairs.pop_front();
        if (out_data.left_out !== want.left_out) begin
          $display("%0t: left_out expected %0d actual %0d", $time,
                   want.left_out, out_data.left_out);
          mismatches++;
        end
        if (out_data.right_out !== want.right_out) begin
          $display("%0t: right_out expected %0d actual %0d", $time,
                   want.right_out, out_data.right_out);
          mismatches++;
        end
        if (out_data.last_out !== want.last_out) begin
          $display("%0t: last_out expected %0b actual %0b", $time,
                   want.last_out, out_data.last_out);
          mismatches++;
        end
      end
    end
  end

  initial begin
    logic [3:0] dir_cnt [5];
    logic [3:0] dir_fmt [5];
    logic [3:0] ext_cnt [6];
    logic [3:0] ext_fmt [6];
    int         idle_of [3];
    logic [3:0] cnt_w;
    logic [3:0] fmt_w;
    dir_cnt = '{4'd6, 4'd8, 4'd8, 4'd8, 4'd3};
    dir_fmt = '{4'(FMT_F32), 4'(FMT_S16), 4'(FMT_S24), 4'(FMT_S32), 4'(FMT_NONE)};
    ext_cnt = '{4'd3, 4'd8, 4'd0, 4'd15, 4'd5, 4'd7};
    ext_fmt = '{4'(FMT_S16), 4'(FMT_S24), 4'(FMT_S32), 4'(FMT_F32), 4'(FMT_NONE), 4'd15};
    idle_of = '{0, 84, 23};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < 5; p++) begin
      if (p > 0) begin
        write_reg(REG_CHANNEL_COUNT, dir_cnt[p]);
        write_reg(REG_SAMPLE_FORMAT, dir_fmt[p]);
      end
      @(negedge clk);
      send_idle = 0;
      load_directed();
      drain();
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 6) begin
        cnt_w = ext_cnt[p];
        fmt_w = ext_fmt[p];
      end else begin
        cnt_w = 4'($urandom_range(15));
        fmt_w = ($urandom_range(4) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(3));
      end
      write_reg(REG_CHANNEL_COUNT, cnt_w);
      write_reg(REG_SAMPLE_FORMAT, fmt_w);
      @(negedge clk);
      send_idle = idle_of[p % 3];
      for (int k = 0; k < PHASE_ITEMS; k++) pending_frames.push_back(random_frame(mix_format));
      drain();
    end

    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
